FILE: hw/rtl/tkmh_pkg.sv
package tkmh_pkg;

	// Sizes
	localparam int HEAP_DEPTH = 64;
	localparam int IDX_W      = $clog2(HEAP_DEPTH);
	localparam int LEN_W      = IDX_W + 1;
	localparam int VAL_W      = 32;
	localparam int ID_W       = 32;
	localparam int CMD_W      = 2;
	localparam int CFG_W      = 7;
	localparam int POS_W      = 6;

	localparam logic [CFG_W-1:0]        LEN_RESET  = CFG_W'(32);
	localparam logic signed [VAL_W-1:0] TOP_VAL    = 32'sh7FFF_FFFF;
	localparam logic signed [VAL_W-1:0] BOTTOM_VAL = 32'sh8000_0000;
	localparam logic [ID_W-1:0]         EMPTY_ID   = 32'hFFFF_FFFF;

	// Commands
	typedef enum logic [CMD_W-1:0] {
		CMD_REPLACE = 2'd0,
		CMD_DRAIN   = 2'd1,
		CMD_REINIT  = 2'd2,
		CMD_NOP     = 2'd3
	} cmd_t;

	// Microprogram step addresses
	typedef enum logic [3:0] {
		ST_IDLE  = 4'd0,
		ST_SIFT  = 4'd1,
		ST_CMP   = 4'd2,
		ST_PLACE = 4'd3,
		ST_RROOT = 4'd4,
		ST_REMIT = 4'd5,
		ST_RINIT = 4'd6,
		ST_DROOT = 4'd7,
		ST_DEMIT = 4'd8,
		ST_DNEXT = 4'd9
	} step_t;

	// Jump conditions
	typedef enum logic [2:0] {
		C_ALWAYS    = 3'd0,
		C_DISPATCH  = 3'd1,
		C_LEAF      = 3'd2,
		C_STOP      = 3'd3,
		C_DRAIN     = 3'd4,
		C_DRAIN_END = 3'd5
	} cond_t;

	// Store read operation
	typedef enum logic [1:0] {
		RD_NONE = 2'd0,
		RD_ROOT = 2'd1,
		RD_KIDS = 2'd2
	} rd_t;

	// Store write operation
	typedef enum logic [1:0] {
		WR_NONE = 2'd0,
		WR_MOVE = 2'd1,
		WR_X    = 2'd2
	} wr_t;

	// Result emission
	typedef enum logic [1:0] {
		EM_NONE  = 2'd0,
		EM_ROOT  = 2'd1,
		EM_DRAIN = 2'd2
	} emit_t;

	// One control word of the microprogram
	typedef struct packed {
		cond_t cond;
		step_t tgt_t;
		step_t tgt_f;
		rd_t   rd;
		wr_t   wr;
		emit_t emit;
		logic  clr;
		logic  cnt_inc;
		logic  x_bottom;
	} uc_word_t;

	// Sequencer to datapath
	typedef struct packed {
		logic  start;
		rd_t   rd;
		wr_t   wr;
		emit_t emit;
		logic  clr;
		logic  cnt_inc;
		logic  x_bottom;
	} ctrl_t;

	// Datapath to sequencer
	typedef struct packed {
		logic leaf;
		logic stop;
		logic drain;
		logic drain_end;
	} stat_t;

	// Datapath to heap store
	typedef struct packed {
		logic                     rd_a_en;
		logic [IDX_W-1:0]         rd_a_addr;
		logic                     rd_b_en;
		logic [IDX_W-1:0]         rd_b_addr;
		logic                     wr_en;
		logic [IDX_W-1:0]         wr_addr;
		logic signed [VAL_W-1:0]  wr_val;
		logic [ID_W-1:0]          wr_id;
		logic                     clr;
		logic [LEN_W-1:0]         clr_len;
	} store_req_t;

	// Heap store read data, unwritten entries already mapped to the reset pair
	typedef struct packed {
		logic signed [VAL_W-1:0] a_val;
		logic [ID_W-1:0]         a_id;
		logic signed [VAL_W-1:0] b_val;
		logic [ID_W-1:0]         b_id;
	} store_rsp_t;

	// Control store
	function automatic uc_word_t uc_rom(input step_t s);
		uc_word_t w;
		w = '{cond: C_ALWAYS, tgt_t: ST_IDLE, tgt_f: ST_IDLE, rd: RD_NONE, wr: WR_NONE,
			emit: EM_NONE, clr: 1'b0, cnt_inc: 1'b0, x_bottom: 1'b0};
		case (s)
			ST_IDLE: begin
				w.cond = C_DISPATCH;
			end
			ST_SIFT: begin
				w.cond  = C_LEAF;
				w.tgt_t = ST_PLACE;
				w.tgt_f = ST_CMP;
				w.rd    = RD_KIDS;
			end
			ST_CMP: begin
				w.cond  = C_STOP;
				w.tgt_t = ST_PLACE;
				w.tgt_f = ST_SIFT;
				w.wr    = WR_MOVE;
			end
			ST_PLACE: begin
				w.cond  = C_DRAIN;
				w.tgt_t = ST_DNEXT;
				w.tgt_f = ST_RROOT;
				w.wr    = WR_X;
			end
			ST_RROOT: begin
				w.tgt_t = ST_REMIT;
				w.rd    = RD_ROOT;
			end
			ST_REMIT: begin
				w.tgt_t = ST_IDLE;
				w.emit  = EM_ROOT;
			end
			ST_RINIT: begin
				w.tgt_t = ST_RROOT;
				w.clr   = 1'b1;
			end
			ST_DROOT: begin
				w.tgt_t = ST_DEMIT;
				w.rd    = RD_ROOT;
			end
			ST_DEMIT: begin
				w.tgt_t    = ST_SIFT;
				w.emit     = EM_DRAIN;
				w.x_bottom = 1'b1;
			end
			ST_DNEXT: begin
				w.cond    = C_DRAIN_END;
				w.tgt_t   = ST_IDLE;
				w.tgt_f   = ST_DROOT;
				w.cnt_inc = 1'b1;
			end
			default: begin
				w.tgt_t = ST_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

FILE: hw/rtl/tkmh_heap_store.sv
module tkmh_heap_store (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tkmh_pkg::store_req_t  req,
	output tkmh_pkg::store_rsp_t  rsp
);

	logic signed [tkmh_pkg::VAL_W-1:0] mem_val [tkmh_pkg::HEAP_DEPTH];
	logic [tkmh_pkg::ID_W-1:0]         mem_id  [tkmh_pkg::HEAP_DEPTH];
	logic [tkmh_pkg::HEAP_DEPTH-1:0]   valid_q;

	logic signed [tkmh_pkg::VAL_W-1:0] a_val_q, b_val_q;
	logic [tkmh_pkg::ID_W-1:0]         a_id_q, b_id_q;
	logic                              a_vld_q, b_vld_q;

	// Write port
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_val[req.wr_addr] <= req.wr_val;
			mem_id[req.wr_addr]  <= req.wr_id;
		end
	end

	// Two registered read ports
	always_ff @(posedge clk) begin
		if (req.rd_a_en) begin
			a_val_q <= mem_val[req.rd_a_addr];
			a_id_q  <= mem_id[req.rd_a_addr];
			a_vld_q <= valid_q[req.rd_a_addr];
		end
		if (req.rd_b_en) begin
			b_val_q <= mem_val[req.rd_b_addr];
			b_id_q  <= mem_id[req.rd_b_addr];
			b_vld_q <= valid_q[req.rd_b_addr];
		end
	end

	// Per-entry written flags; reset clears them all, reinit those below the heap length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.clr) begin
			for (int i = 0; i < tkmh_pkg::HEAP_DEPTH; i++) begin
				if (tkmh_pkg::LEN_W'(i) < req.clr_len) begin
					valid_q[i] <= 1'b0;
				end
			end
		end else if (req.wr_en) begin
			valid_q[req.wr_addr] <= 1'b1;
		end
	end

	// Unwritten entries read as the reset pair
	always_comb begin
		rsp.a_val = a_vld_q ? a_val_q : tkmh_pkg::TOP_VAL;
		rsp.a_id  = a_vld_q ? a_id_q  : tkmh_pkg::EMPTY_ID;
		rsp.b_val = b_vld_q ? b_val_q : tkmh_pkg::TOP_VAL;
		rsp.b_id  = b_vld_q ? b_id_q  : tkmh_pkg::EMPTY_ID;
	end

endmodule

FILE: hw/rtl/tkmh_useq.sv
module tkmh_useq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_accept,
	input  logic [tkmh_pkg::CMD_W-1:0]    cmd,
	input  logic                          out_free,
	input  tkmh_pkg::stat_t               stat,
	output tkmh_pkg::ctrl_t               ctrl,
	output logic                          busy
);

	tkmh_pkg::step_t    upc_q, upc_d;
	tkmh_pkg::uc_word_t word;
	tkmh_pkg::cmd_t     cmd_in;
	logic               go;
	logic               cond_hit;

	assign word   = tkmh_pkg::uc_rom(upc_q);
	assign cmd_in = tkmh_pkg::cmd_t'(cmd);
	assign busy   = (upc_q != tkmh_pkg::ST_IDLE);

	// An emitting step waits for the output register
	assign go = !((word.emit != tkmh_pkg::EM_NONE) && !out_free);

	// Condition select
	always_comb begin
		case (word.cond)
			tkmh_pkg::C_LEAF:      cond_hit = stat.leaf;
			tkmh_pkg::C_STOP:      cond_hit = stat.stop;
			tkmh_pkg::C_DRAIN:     cond_hit = stat.drain;
			tkmh_pkg::C_DRAIN_END: cond_hit = stat.drain_end;
			default:               cond_hit = 1'b1;
		endcase
	end

	// Next step
	always_comb begin
		upc_d = upc_q;
		if (word.cond == tkmh_pkg::C_DISPATCH) begin
			if (in_accept) begin
				case (cmd_in)
					tkmh_pkg::CMD_REPLACE: upc_d = tkmh_pkg::ST_SIFT;
					tkmh_pkg::CMD_DRAIN:   upc_d = tkmh_pkg::ST_DROOT;
					tkmh_pkg::CMD_REINIT:  upc_d = tkmh_pkg::ST_RINIT;
					default:               upc_d = tkmh_pkg::ST_IDLE;
				endcase
			end
		end else if (go) begin
			upc_d = cond_hit ? word.tgt_t : word.tgt_f;
		end
	end

	// Control outputs
	always_comb begin
		ctrl.start    = in_accept;
		ctrl.rd       = go ? word.rd   : tkmh_pkg::RD_NONE;
		ctrl.wr       = go ? word.wr   : tkmh_pkg::WR_NONE;
		ctrl.emit     = go ? word.emit : tkmh_pkg::EM_NONE;
		ctrl.clr      = go & word.clr;
		ctrl.cnt_inc  = go & word.cnt_inc;
		ctrl.x_bottom = go & word.x_bottom;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= tkmh_pkg::ST_IDLE;
		end else begin
			upc_q <= upc_d;
		end
	end

endmodule

FILE: hw/rtl/tkmh_datapath.sv
module tkmh_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tkmh_pkg::ctrl_t                   ctrl,
	input  logic [tkmh_pkg::CMD_W-1:0]        cmd,
	input  logic signed [tkmh_pkg::VAL_W-1:0] new_val,
	input  logic [tkmh_pkg::ID_W-1:0]         new_id,
	input  logic [tkmh_pkg::CFG_W-1:0]        heap_len,
	input  tkmh_pkg::store_rsp_t              rsp,
	output tkmh_pkg::store_req_t              req,
	output tkmh_pkg::stat_t                   stat,
	output logic signed [tkmh_pkg::VAL_W-1:0] res_val,
	output logic [tkmh_pkg::ID_W-1:0]         res_id,
	output logic [tkmh_pkg::POS_W-1:0]        res_pos,
	output logic                              res_last
);

	tkmh_pkg::cmd_t                    cmd_q;
	logic [tkmh_pkg::LEN_W-1:0]        n_q, cnt_q;
	logic [tkmh_pkg::IDX_W-1:0]        node_q;
	logic signed [tkmh_pkg::VAL_W-1:0] x_val_q;
	logic [tkmh_pkg::ID_W-1:0]         x_id_q;

	logic [tkmh_pkg::LEN_W-1:0]        eff_len;
	logic [tkmh_pkg::LEN_W-1:0]        lc;
	logic [tkmh_pkg::LEN_W:0]          rc;
	logic                              has_r, pick_r;
	logic [tkmh_pkg::IDX_W-1:0]        c_idx;
	logic signed [tkmh_pkg::VAL_W-1:0] c_val;
	logic [tkmh_pkg::ID_W-1:0]         c_id;
	logic [tkmh_pkg::LEN_W-1:0]        cnt_nx;
	logic                              move;

	// Length clamp: zero acts as one, above depth acts as depth
	always_comb begin
		if (heap_len == '0) begin
			eff_len = tkmh_pkg::LEN_W'(1);
		end else if (heap_len > tkmh_pkg::CFG_W'(tkmh_pkg::HEAP_DEPTH)) begin
			eff_len = tkmh_pkg::LEN_W'(tkmh_pkg::HEAP_DEPTH);
		end else begin
			eff_len = heap_len[tkmh_pkg::LEN_W-1:0];
		end
	end

	// Child indexes and selection; ties go to the right child
	assign lc     = {node_q, 1'b1};
	assign rc     = {1'b0, lc} + (tkmh_pkg::LEN_W+1)'(1);
	assign has_r  = rc < {1'b0, n_q};
	assign pick_r = has_r && !(rsp.a_val > rsp.b_val);
	assign c_idx  = pick_r ? rc[tkmh_pkg::IDX_W-1:0] : lc[tkmh_pkg::IDX_W-1:0];
	assign c_val  = pick_r ? rsp.b_val : rsp.a_val;
	assign c_id   = pick_r ? rsp.b_id  : rsp.a_id;
	assign cnt_nx = cnt_q + tkmh_pkg::LEN_W'(1);

	// Status to sequencer
	always_comb begin
		stat.leaf      = (lc >= n_q);
		stat.drain     = (cmd_q == tkmh_pkg::CMD_DRAIN);
		stat.stop      = stat.drain ? (c_id == tkmh_pkg::EMPTY_ID) : !(c_val > x_val_q);
		stat.drain_end = (cnt_nx == n_q);
	end

	assign move = (ctrl.wr == tkmh_pkg::WR_MOVE) && !stat.stop;

	// Store requests: port A takes left child or root, port B the right child
	always_comb begin
		req.rd_a_en   = (ctrl.rd != tkmh_pkg::RD_NONE);
		req.rd_a_addr = (ctrl.rd == tkmh_pkg::RD_KIDS) ? lc[tkmh_pkg::IDX_W-1:0] : '0;
		req.rd_b_en   = (ctrl.rd == tkmh_pkg::RD_KIDS);
		req.rd_b_addr = rc[tkmh_pkg::IDX_W-1:0];
		req.wr_en     = move || (ctrl.wr == tkmh_pkg::WR_X);
		req.wr_addr   = node_q;
		req.wr_val    = move ? c_val : x_val_q;
		req.wr_id     = move ? c_id  : x_id_q;
		req.clr       = ctrl.clr;
		req.clr_len   = n_q;
	end

	// Result payload
	always_comb begin
		res_val = rsp.a_val;
		res_id  = rsp.a_id;
		if (ctrl.emit == tkmh_pkg::EM_DRAIN) begin
			res_pos  = tkmh_pkg::POS_W'(n_q - cnt_nx);
			res_last = stat.drain_end;
		end else begin
			res_pos  = '0;
			res_last = 1'b1;
		end
	end

	// Command and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q  <= tkmh_pkg::CMD_NOP;
			n_q    <= tkmh_pkg::LEN_W'(1);
			cnt_q  <= '0;
			node_q <= '0;
		end else begin
			if (ctrl.start) begin
				cmd_q  <= tkmh_pkg::cmd_t'(cmd);
				n_q    <= eff_len;
				cnt_q  <= '0;
				node_q <= '0;
			end else begin
				if (ctrl.cnt_inc) begin
					cnt_q <= cnt_nx;
				end
				if (ctrl.x_bottom) begin
					node_q <= '0;
				end else if (move) begin
					node_q <= c_idx;
				end
			end
		end
	end

	// Element being sifted
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			x_val_q <= new_val;
			x_id_q  <= new_id;
		end else if (ctrl.x_bottom) begin
			x_val_q <= tkmh_pkg::BOTTOM_VAL;
			x_id_q  <= tkmh_pkg::EMPTY_ID;
		end
	end

endmodule

FILE: hw/rtl/top_k_max_heap.sv
// Binary max-heap of (distance, id) pairs for k-nearest selection, run by a small
// microprogram over a two-read, one-write heap store. Replace puts the new pair at
// the root and sinks it level by level (a registered read of both children, then a
// compare and move) until a leaf or a compare stops it, then places the pair and
// reads back the root as the result. Drain reads out the root, puts a bottom value
// in its place and sinks it until a leaf or an empty child stops it, heap_len items
// in all. Reinit clears the per-entry written flags below the heap length and
// returns the root. Command 3 is taken and gives no result. Input stall stays high
// while a command is in work; a result waits in the output register and holds the
// sequencer only when the next result is due before the previous one is taken.
// heap_len is to be written only while idle; the block itself does not enforce
// this. 0 acts as 1 and values above 64 act as 64.
module top_k_max_heap (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [tkmh_pkg::CFG_W-1:0]        cfg_wr_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [tkmh_pkg::CMD_W-1:0]        cmd,
	input  logic signed [tkmh_pkg::VAL_W-1:0] new_val,
	input  logic [tkmh_pkg::ID_W-1:0]         new_id,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [tkmh_pkg::VAL_W-1:0] out_val,
	output logic [tkmh_pkg::ID_W-1:0]         out_id,
	output logic [tkmh_pkg::POS_W-1:0]        out_pos,
	output logic                              last
);

	logic [tkmh_pkg::CFG_W-1:0]        heap_len_q;
	logic                              busy, in_accept, out_free;
	tkmh_pkg::ctrl_t                   ctrl;
	tkmh_pkg::stat_t                   stat;
	tkmh_pkg::store_req_t              req;
	tkmh_pkg::store_rsp_t              rsp;
	logic signed [tkmh_pkg::VAL_W-1:0] res_val;
	logic [tkmh_pkg::ID_W-1:0]         res_id;
	logic [tkmh_pkg::POS_W-1:0]        res_pos;
	logic                              res_last;

	logic                              out_valid_q;
	logic signed [tkmh_pkg::VAL_W-1:0] out_val_q;
	logic [tkmh_pkg::ID_W-1:0]         out_id_q;
	logic [tkmh_pkg::POS_W-1:0]        out_pos_q;
	logic                              last_q;
	logic                              load_out;

	// Input handshake
	assign in_stall  = busy;
	assign in_accept = in_valid && !busy;
	assign out_free  = !out_valid_q || !out_stall;
	assign load_out  = (ctrl.emit != tkmh_pkg::EM_NONE);

	// Length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_len_q <= tkmh_pkg::LEN_RESET;
		end else if (cfg_wr_en) begin
			heap_len_q <= cfg_wr_data;
		end
	end

	tkmh_useq u_useq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.cmd       (cmd),
		.out_free  (out_free),
		.stat      (stat),
		.ctrl      (ctrl),
		.busy      (busy)
	);

	tkmh_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.cmd      (cmd),
		.new_val  (new_val),
		.new_id   (new_id),
		.heap_len (heap_len_q),
		.rsp      (rsp),
		.req      (req),
		.stat     (stat),
		.res_val  (res_val),
		.res_id   (res_id),
		.res_pos  (res_pos),
		.res_last (res_last)
	);

	tkmh_heap_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// Output register: valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register: payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_val_q <= res_val;
			out_id_q  <= res_id;
			out_pos_q <= res_pos;
			last_q    <= res_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_val   = out_val_q;
	assign out_id    = out_id_q;
	assign out_pos   = out_pos_q;
	assign last      = last_q;

endmodule

FILE: verif/top_k_max_heap_tb.sv
module top_k_max_heap_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// no transfer in either direction for this long means the block is hung
	localparam int QUIET_LIMIT   = 4000;
	// cycles after the last result before the block counts as idle
	localparam int SETTLE_CYCLES = 24;
	localparam int RANDOM_ITEMS  = 170;

	typedef struct {
		logic signed [tkmh_pkg::VAL_W-1:0] dval;
		logic [tkmh_pkg::ID_W-1:0]         ident;
		logic [tkmh_pkg::POS_W-1:0]        pos;
		logic                              fin;
	} heap_result_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              cfg_wr_en = 1'b0;
	logic [tkmh_pkg::CFG_W-1:0]        cfg_wr_data = '0;
	logic                              in_valid = 1'b0;
	logic                              in_stall;
	logic [tkmh_pkg::CMD_W-1:0]        cmd = tkmh_pkg::CMD_NOP;
	logic signed [tkmh_pkg::VAL_W-1:0] new_val = '0;
	logic [tkmh_pkg::ID_W-1:0]         new_id = '0;
	logic                              out_valid;
	logic                              out_stall = 1'b0;
	logic signed [tkmh_pkg::VAL_W-1:0] out_val;
	logic [tkmh_pkg::ID_W-1:0]         out_id;
	logic [tkmh_pkg::POS_W-1:0]        out_pos;
	logic                              last;

	// shadow heap and its length register
	logic signed [tkmh_pkg::VAL_W-1:0] shadow_val [tkmh_pkg::HEAP_DEPTH];
	logic [tkmh_pkg::ID_W-1:0]         shadow_id [tkmh_pkg::HEAP_DEPTH];
	logic [tkmh_pkg::CFG_W-1:0]        shadow_len;

	heap_result_t pending_results[$];

	int errors        = 0;
	int in_transfers  = 0;
	int out_transfers = 0;
	int drains_sent   = 0;
	int quiet_cycles  = 0;
	int rx_hold       = 0;
	bit tx_idles      = 1'b1;
	bit rx_idles      = 1'b1;

	top_k_max_heap uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.new_val    (new_val),
		.new_id     (new_id),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_val    (out_val),
		.out_id     (out_id),
		.out_pos    (out_pos),
		.last       (last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Heap predictor
	// ---------------------------------------------------------------

	function automatic void shadow_reset();
		for (int i = 0; i < tkmh_pkg::HEAP_DEPTH; i++) begin
			shadow_val[i] = tkmh_pkg::TOP_VAL;
			shadow_id[i]  = tkmh_pkg::EMPTY_ID;
		end
		shadow_len = tkmh_pkg::LEN_RESET;
	endfunction

	// length in use: 0 acts as 1, anything past the depth is clipped
	function automatic int unsigned heap_size();
		if (shadow_len == 0)
			return 1;
		if (shadow_len > tkmh_pkg::HEAP_DEPTH)
			return tkmh_pkg::HEAP_DEPTH;
		return shadow_len;
	endfunction

	// right child wins ties
	function automatic int unsigned larger_child(input int unsigned node, input int unsigned n);
		int unsigned l;
		l = 2 * node + 1;
		if (l + 1 < n)
			return (shadow_val[l] > shadow_val[l + 1]) ? l : l + 1;
		return l;
	endfunction

	function automatic void swap_slots(input int unsigned a, input int unsigned b);
		logic signed [tkmh_pkg::VAL_W-1:0] tv;
		logic [tkmh_pkg::ID_W-1:0]         ti;
		tv            = shadow_val[a];
		ti            = shadow_id[a];
		shadow_val[a] = shadow_val[b];
		shadow_id[a]  = shadow_id[b];
		shadow_val[b] = tv;
		shadow_id[b]  = ti;
	endfunction

	function automatic void push_result(input logic signed [tkmh_pkg::VAL_W-1:0] v,
			input logic [tkmh_pkg::ID_W-1:0] id, input int unsigned pos, input logic fin);
		heap_result_t r;
		r.dval  = v;
		r.ident = id;
		r.pos   = tkmh_pkg::POS_W'(pos);
		r.fin   = fin;
		pending_results.push_back(r);
	endfunction

	function automatic void predict_replace(input logic signed [tkmh_pkg::VAL_W-1:0] v,
			input logic [tkmh_pkg::ID_W-1:0] id);
		int unsigned n, node, kid;
		bit sinking;
		n             = heap_size();
		shadow_val[0] = v;
		shadow_id[0]  = id;
		node          = 0;
		sinking       = 1'b1;
		while (sinking && (2 * node + 1 < n)) begin
			kid = larger_child(node, n);
			if (shadow_val[kid] > shadow_val[node]) begin
				swap_slots(node, kid);
				node = kid;
			end else begin
				sinking = 1'b0;
			end
		end
		push_result(shadow_val[0], shadow_id[0], 0, 1'b1);
	endfunction

	// extraction: root goes out, bottom value sinks until an empty child blocks it
	function automatic void predict_drain();
		int unsigned n, node, kid;
		bit sinking;
		n = heap_size();
		for (int unsigned i = 0; i < n; i++) begin
			push_result(shadow_val[0], shadow_id[0], n - 1 - i, (i + 1 == n));
			shadow_val[0] = tkmh_pkg::BOTTOM_VAL;
			shadow_id[0]  = tkmh_pkg::EMPTY_ID;
			node          = 0;
			sinking       = 1'b1;
			while (sinking && (2 * node + 1 < n)) begin
				kid = larger_child(node, n);
				if (shadow_id[kid] == tkmh_pkg::EMPTY_ID) begin
					sinking = 1'b0;
				end else begin
					swap_slots(node, kid);
					node = kid;
				end
			end
		end
	endfunction

	function automatic void predict_reinit();
		int unsigned n;
		n = heap_size();
		for (int unsigned i = 0; i < n; i++) begin
			shadow_val[i] = tkmh_pkg::TOP_VAL;
			shadow_id[i]  = tkmh_pkg::EMPTY_ID;
		end
		push_result(shadow_val[0], shadow_id[0], 0, 1'b1);
	endfunction

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------

	// distances lean on extremes and a narrow band so ties are common
	function automatic logic signed [tkmh_pkg::VAL_W-1:0] pick_dist();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 6)
			return tkmh_pkg::TOP_VAL;
		if (sel < 12)
			return tkmh_pkg::BOTTOM_VAL;
		if (sel < 16)
			return -1;
		if (sel < 45)
			return int'($urandom_range(0, 16)) - 8;
		return $urandom;
	endfunction

	function automatic logic [tkmh_pkg::ID_W-1:0] pick_ident();
		if ($urandom_range(0, 99) < 8)
			return tkmh_pkg::EMPTY_ID;
		return $urandom;
	endfunction

	// valid stays up after a transfer until the next item or a release
	task automatic send_item(input tkmh_pkg::cmd_t c,
			input logic signed [tkmh_pkg::VAL_W-1:0] v, input logic [tkmh_pkg::ID_W-1:0] id);
		if (tx_idles && ($urandom_range(0, 99) < 25)) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < 25)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= c;
		new_val  <= v;
		new_id   <= id;
		do
			@(posedge clk);
		while (in_stall);
		case (c)
			tkmh_pkg::CMD_REPLACE: predict_replace(v, id);
			tkmh_pkg::CMD_DRAIN: begin
				predict_drain();
				drains_sent++;
			end
			tkmh_pkg::CMD_REINIT:  predict_reinit();
			default: ;
		endcase
	endtask

	task automatic send_random_payload(input tkmh_pkg::cmd_t c);
		send_item(c, $urandom, $urandom);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_len(input logic [tkmh_pkg::CFG_W-1:0] v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		shadow_len = v;
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// fill a fresh heap with random pairs, then pull it out
	task automatic fill_and_drain(input int unsigned fills);
		send_random_payload(tkmh_pkg::CMD_REINIT);
		repeat (fills) send_item(tkmh_pkg::CMD_REPLACE, pick_dist(), pick_ident());
		send_random_payload(tkmh_pkg::CMD_DRAIN);
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// drain straight out of reset, then reinit
	task automatic test_reset_contents();
		send_random_payload(tkmh_pkg::CMD_DRAIN);
		send_random_payload(tkmh_pkg::CMD_REINIT);
		wait_drained();
	endtask

	// field extremes, ties, empty ids and the unused command on a small heap
	task automatic test_field_edges();
		write_len(7'd4);
		send_item(tkmh_pkg::CMD_REPLACE, 5, 32'd10);
		send_item(tkmh_pkg::CMD_REPLACE, 5, 32'd11);
		send_item(tkmh_pkg::CMD_REPLACE, -1, 32'd12);
		send_item(tkmh_pkg::CMD_REPLACE, tkmh_pkg::BOTTOM_VAL, 32'd0);
		send_item(tkmh_pkg::CMD_REPLACE, tkmh_pkg::TOP_VAL, tkmh_pkg::EMPTY_ID);
		send_item(tkmh_pkg::CMD_NOP, tkmh_pkg::TOP_VAL, tkmh_pkg::EMPTY_ID);
		send_item(tkmh_pkg::CMD_REPLACE, 0, 32'h5555_AAAA);
		send_random_payload(tkmh_pkg::CMD_DRAIN);
		send_random_payload(tkmh_pkg::CMD_REINIT);
		wait_drained();
	endtask

	// length register below one and above the depth
	task automatic test_length_extremes();
		write_len(7'd0);
		send_item(tkmh_pkg::CMD_REPLACE, 7, 32'd1);
		send_random_payload(tkmh_pkg::CMD_DRAIN);
		wait_drained();
		write_len(7'd127);
		send_item(tkmh_pkg::CMD_REPLACE, 100, 32'hAAAA_5555);
		send_item(tkmh_pkg::CMD_REPLACE, -100, 32'd2);
		send_random_payload(tkmh_pkg::CMD_DRAIN);
		wait_drained();
		write_len(7'd1);
		send_item(tkmh_pkg::CMD_REPLACE, -7, 32'd3);
		send_random_payload(tkmh_pkg::CMD_DRAIN);
		wait_drained();
	endtask

	// back-to-back transfers with neither side idling
	task automatic test_streaming();
		tx_idles = 1'b0;
		rx_idles = 1'b0;
		write_len(7'd6);
		repeat (3) fill_and_drain(10);
		wait_drained();
		tx_idles = 1'b1;
		rx_idles = 1'b1;
	endtask

	// receiver holds off long enough that input stalls, then the sender pauses
	task automatic test_backpressure();
		write_len(7'd8);
		rx_hold = 400;
		fill_and_drain(12);
		wait_drained();
		fill_and_drain(5);
		wait_drained();
	endtask

	// mostly well-formed fill/drain sequences at changing lengths, some noise
	task automatic test_random_sequences(input int unsigned budget);
		int unsigned sent, phase, fills, sel, n;
		tkmh_pkg::cmd_t c;
		sent  = 0;
		phase = 0;
		while (sent < budget) begin
			if (phase % 3 == 0) begin
				wait_drained();
				sel = $urandom_range(0, 99);
				if (sel < 5)
					write_len(7'd64);
				else if (sel < 8)
					write_len(tkmh_pkg::CFG_W'($urandom_range(65, 127)));
				else
					write_len(tkmh_pkg::CFG_W'($urandom_range(1, 12)));
			end
			phase++;
			n = heap_size();
			if ($urandom_range(0, 99) < 20) begin
				repeat ($urandom_range(1, 4)) begin
					c = tkmh_pkg::cmd_t'($urandom_range(0, 3));
					send_item(c, pick_dist(), pick_ident());
					if (c != tkmh_pkg::CMD_NOP)
						sent++;
				end
			end else begin
				fills = $urandom_range(1, (2 * n + 2 < 40) ? 2 * n + 2 : 40);
				send_random_payload(tkmh_pkg::CMD_REINIT);
				repeat (fills) send_item(tkmh_pkg::CMD_REPLACE, pick_dist(), pick_ident());
				sent += fills + 1;
				// some sequences stop short of the drain
				if ($urandom_range(0, 99) < 85) begin
					send_random_payload(tkmh_pkg::CMD_DRAIN);
					sent++;
				end
			end
		end
		wait_drained();
	endtask

	// ---------------------------------------------------------------
	// Receiver: long hold first, then random stalls
	// ---------------------------------------------------------------
	initial begin
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				out_stall <= 1'b1;
				rx_hold--;
			end else if (rx_idles) begin
				out_stall <= ($urandom_range(0, 99) < 25);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// Result checker and hang watchdog
	// ---------------------------------------------------------------
	initial begin
		heap_result_t want;
		forever begin
			@(posedge clk);
			if (in_valid && !in_stall)
				in_transfers++;
			if (arst_n && out_valid && !out_stall) begin
				out_transfers++;
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual val %0d id %h pos %0d last %b",
						$time, out_val, out_id, out_pos, last);
					errors++;
				end else begin
					want = pending_results.pop_front();
					if (out_val !== want.dval) begin
						$display("%0t: out_val expected %0d, actual %0d", $time, want.dval, out_val);
						errors++;
					end
					if (out_id !== want.ident) begin
						$display("%0t: out_id expected %h, actual %h", $time, want.ident, out_id);
						errors++;
					end
					if (out_pos !== want.pos) begin
						$display("%0t: out_pos expected %0d, actual %0d", $time, want.pos, out_pos);
						errors++;
					end
					if (last !== want.fin) begin
						$display("%0t: last expected %b, actual %b", $time, want.fin, last);
						errors++;
					end
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no transfer for %0d cycles, %0d results outstanding",
					$time, quiet_cycles, pending_results.size());
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// Test sequence
	// ---------------------------------------------------------------
	initial begin
		shadow_reset();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_contents();
		test_field_edges();
		test_length_extremes();
		test_streaming();
		test_backpressure();
		test_random_sequences(RANDOM_ITEMS);
		wait_drained();
		if (pending_results.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, pending_results.size());
			errors++;
		end
		$display("Run covered %0d commands in and %0d results out, %0d of them drains,",
			in_transfers, out_transfers, drains_sent);
		$display("heap lengths 0 through 127, output hold-off, pauses and %0d mismatches.", errors);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
